>>> rtl/core/smec_pkg.sv
// Shared types, constants and helpers for the sensor marker event classifier.
// Depends on nothing; used by every module under rtl/core.
`default_nettype none

package smec_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] CENTER_MASK = 8'h7E;
    localparam logic [7:0] EDGE_MASK   = 8'h81;
    localparam logic [7:0] EDGE_LOW    = 8'h01;
    localparam logic [7:0] EDGE_HIGH   = 8'h80;
    localparam logic [15:0] COUNT16_MAX = 16'hFFFF;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_WIDE_THR     = 3'd0;
    localparam logic [2:0] REG_WIDE_MIN     = 3'd1;
    localparam logic [2:0] REG_CROSS_CLEAR  = 3'd2;
    localparam logic [2:0] REG_EDGE_CLEAR   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT      = 3'd4;

    typedef enum logic [2:0] {
        KIND_CROSS   = 3'd0,
        KIND_BOTH    = 3'd1,
        KIND_EDGE0   = 3'd2,
        KIND_EDGE7   = 3'd3,
        KIND_UNKNOWN = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic [2:0]  wide_center_threshold;
        logic [15:0] wide_min_frames;
        logic [15:0] cross_clear_frames;
        logic [15:0] edge_clear_frames;
        logic [31:0] timeout_frames;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  sensor_bits;
        logic [31:0] frame_index;
    } item_t;

    typedef struct packed {
        logic        event_done;
        logic [2:0]  event_kind;
        logic [7:0]  edge_seen;
        logic [7:0]  all_seen;
        logic [2:0]  peak_center;
        logic [15:0] longest_wide_run;
        logic [31:0] first_frame;
        logic [31:0] last_frame;
        logic [31:0] span_frames;
        logic [31:0] episodes_total;
    } result_t;

    // Count lit center sensors (bits 1..6)
    function automatic logic [2:0] popcount_center(input logic [7:0] bits);
        logic [7:0] masked;
        logic [2:0] n;
        masked = bits & CENTER_MASK;
        n = 3'd0;
        for (int i = 1; i < 7; i++) begin
            n = n + {2'b00, masked[i]};
        end
        return n;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == COUNT16_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/smec_cfg.sv
// APB configuration register file of the classifier.
// Depends on smec_pkg (cfg_t, register indexes).
`default_nettype none

module smec_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smec_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [smec_pkg::DATA_W-1:0]   pwdata,
    output logic [smec_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    output smec_pkg::cfg_t                     cfg
);

    smec_pkg::cfg_t cfg_reg;
    smec_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                smec_pkg::REG_WIDE_THR:    cfg_next.wide_center_threshold = pwdata[2:0];
                smec_pkg::REG_WIDE_MIN:    cfg_next.wide_min_frames = pwdata[15:0];
                smec_pkg::REG_CROSS_CLEAR: cfg_next.cross_clear_frames = pwdata[15:0];
                smec_pkg::REG_EDGE_CLEAR:  cfg_next.edge_clear_frames = pwdata[15:0];
                smec_pkg::REG_TIMEOUT:     cfg_next.timeout_frames = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_center_threshold <= 3'd4;
            cfg_reg.wide_min_frames       <= 16'd3;
            cfg_reg.cross_clear_frames    <= 16'd5;
            cfg_reg.edge_clear_frames     <= 16'd3;
            cfg_reg.timeout_frames        <= 32'd200;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            smec_pkg::REG_WIDE_THR:    prdata = {29'd0, cfg_reg.wide_center_threshold};
            smec_pkg::REG_WIDE_MIN:    prdata = {16'd0, cfg_reg.wide_min_frames};
            smec_pkg::REG_CROSS_CLEAR: prdata = {16'd0, cfg_reg.cross_clear_frames};
            smec_pkg::REG_EDGE_CLEAR:  prdata = {16'd0, cfg_reg.edge_clear_frames};
            smec_pkg::REG_TIMEOUT:     prdata = cfg_reg.timeout_frames;
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/smec_episode.sv
// Episode tracker: holds the open-episode state and forms one result per request.
// Depends on smec_pkg (item_t, result_t, cfg_t, helpers).
`default_nettype none

module smec_episode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire smec_pkg::cfg_t  cfg,
    input  wire smec_pkg::item_t item,
    input  wire logic            commit,
    output smec_pkg::result_t    result
);

    logic        collecting_reg, collecting_next;
    logic [7:0]  edge_acc_reg, edge_acc_next;
    logic [7:0]  all_acc_reg, all_acc_next;
    logic [2:0]  peak_reg, peak_next;
    logic [15:0] wrc_reg, wrc_next;
    logic [15:0] wrp_reg, wrp_next;
    logic [15:0] quiet_reg, quiet_next;
    logic [31:0] open_frame_reg, open_frame_next;
    logic [31:0] active_frame_reg, active_frame_next;
    logic [31:0] ep_count_reg, ep_count_next;

    logic [2:0]  center;
    logic [7:0]  edges;
    logic        wide, active, opening, upd;
    logic [7:0]  base_edge, base_all;
    logic [2:0]  base_peak;
    logic [15:0] base_wrc, base_wrp, base_quiet;
    logic [31:0] base_open, base_active;
    logic [7:0]  upd_edge, upd_all;
    logic [2:0]  upd_peak;
    logic [15:0] upd_wrc, upd_wrp, upd_quiet, upd_limit;
    logic [31:0] upd_active, upd_age;
    logic        do_close;
    logic [7:0]  sel_edge, sel_all;
    logic [2:0]  sel_peak;
    logic [15:0] sel_wrp;
    logic [31:0] sel_open, sel_active;
    smec_pkg::event_kind_t kind;

    always_comb begin
        center  = smec_pkg::popcount_center(item.sensor_bits);
        edges   = item.sensor_bits & smec_pkg::EDGE_MASK;
        wide    = center >= cfg.wide_center_threshold;
        active  = wide || (edges != 8'd0);
        opening = !item.command && !collecting_reg && active;
        upd     = !item.command && (collecting_reg || active);

        // Fresh episode starts from cleared accumulators
        base_edge   = opening ? 8'd0 : edge_acc_reg;
        base_all    = opening ? 8'd0 : all_acc_reg;
        base_peak   = opening ? 3'd0 : peak_reg;
        base_wrc    = opening ? 16'd0 : wrc_reg;
        base_wrp    = opening ? 16'd0 : wrp_reg;
        base_quiet  = opening ? 16'd0 : quiet_reg;
        base_open   = opening ? item.frame_index : open_frame_reg;
        base_active = opening ? item.frame_index : active_frame_reg;

        upd_edge   = base_edge | edges;
        upd_all    = base_all | item.sensor_bits;
        upd_peak   = (center > base_peak) ? center : base_peak;
        upd_wrc    = wide ? smec_pkg::sat_inc16(base_wrc) : 16'd0;
        upd_wrp    = (wide && (upd_wrc > base_wrp)) ? upd_wrc : base_wrp;
        upd_quiet  = active ? 16'd0 : smec_pkg::sat_inc16(base_quiet);
        upd_active = active ? item.frame_index : base_active;
        upd_limit  = (upd_wrp >= cfg.wide_min_frames) ? cfg.cross_clear_frames
                                                      : cfg.edge_clear_frames;
        upd_age    = item.frame_index - base_open + 32'd1;

        do_close = (item.command && collecting_reg)
                || (upd && ((upd_quiet >= upd_limit) || (upd_age >= cfg.timeout_frames)));

        // Flush reports the held episode; an update reports the refreshed one
        sel_edge   = item.command ? edge_acc_reg : upd_edge;
        sel_all    = item.command ? all_acc_reg : upd_all;
        sel_peak   = item.command ? peak_reg : upd_peak;
        sel_wrp    = item.command ? wrp_reg : upd_wrp;
        sel_open   = item.command ? open_frame_reg : base_open;
        sel_active = item.command ? active_frame_reg : upd_active;

        if (sel_wrp >= cfg.wide_min_frames) begin
            kind = smec_pkg::KIND_CROSS;
        end else if (sel_edge == smec_pkg::EDGE_MASK) begin
            kind = smec_pkg::KIND_BOTH;
        end else if (sel_edge == smec_pkg::EDGE_LOW) begin
            kind = smec_pkg::KIND_EDGE0;
        end else if (sel_edge == smec_pkg::EDGE_HIGH) begin
            kind = smec_pkg::KIND_EDGE7;
        end else begin
            kind = smec_pkg::KIND_UNKNOWN;
        end

        collecting_next   = collecting_reg;
        edge_acc_next     = edge_acc_reg;
        all_acc_next      = all_acc_reg;
        peak_next         = peak_reg;
        wrc_next          = wrc_reg;
        wrp_next          = wrp_reg;
        quiet_next        = quiet_reg;
        open_frame_next   = open_frame_reg;
        active_frame_next = active_frame_reg;
        ep_count_next     = ep_count_reg;
        if (upd) begin
            collecting_next   = 1'b1;
            edge_acc_next     = upd_edge;
            all_acc_next      = upd_all;
            peak_next         = upd_peak;
            wrc_next          = upd_wrc;
            wrp_next          = upd_wrp;
            quiet_next        = upd_quiet;
            open_frame_next   = base_open;
            active_frame_next = upd_active;
        end
        if (do_close) begin
            collecting_next = 1'b0;
            quiet_next      = 16'd0;
            wrc_next        = 16'd0;
            ep_count_next   = ep_count_reg + 32'd1;
        end

        result = '0;
        if (do_close) begin
            result.event_done       = 1'b1;
            result.event_kind       = kind;
            result.edge_seen        = sel_edge;
            result.all_seen         = sel_all;
            result.peak_center      = sel_peak;
            result.longest_wide_run = sel_wrp;
            result.first_frame      = sel_open;
            result.last_frame       = sel_active;
            result.span_frames      = (sel_active >= sel_open)
                                    ? (sel_active - sel_open + 32'd1) : 32'd0;
            result.episodes_total   = ep_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg   <= 1'b0;
            edge_acc_reg     <= '0;
            all_acc_reg      <= '0;
            peak_reg         <= '0;
            wrc_reg          <= '0;
            wrp_reg          <= '0;
            quiet_reg        <= '0;
            open_frame_reg   <= '0;
            active_frame_reg <= '0;
            ep_count_reg     <= '0;
        end else if (commit) begin
            collecting_reg   <= collecting_next;
            edge_acc_reg     <= edge_acc_next;
            all_acc_reg      <= all_acc_next;
            peak_reg         <= peak_next;
            wrc_reg          <= wrc_next;
            wrp_reg          <= wrp_next;
            quiet_reg        <= quiet_next;
            open_frame_reg   <= open_frame_next;
            active_frame_reg <= active_frame_next;
            ep_count_reg     <= ep_count_next;
        end
    end

    // Closed episode bumps the episode counter by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && result.event_done |=> ep_count_reg == $past(ep_count_reg) + 32'd1)
        else $error("episode count did not advance on close");

    // An idle tracker with no open episode never closes on a flush
    a_flush_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item.command && !collecting_reg |-> !result.event_done)
        else $error("flush while idle reported an event");

    // Wide run peak never falls below the current run while collecting
    a_run_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        collecting_reg |-> wrp_reg >= wrc_reg)
        else $error("wide run exceeds its recorded peak");

endmodule

`default_nettype wire

>>> rtl/core/sensor_marker_event_classifier.sv
// Top level of the line-sensor marker event classifier.
// Depends on smec_pkg, smec_cfg and smec_episode.
//
// Usage:
//   Input channel (s_*): each request is a sensor frame (s_command = 0) with
//   its frame number, or a flush (s_command = 1) that closes any open episode.
//   Result channel (m_*): exactly one result per request. m_event_done = 1
//   marks a closed episode with its kind and statistics; otherwise every
//   result field is zero.
//   Configuration: APB registers at byte addresses 0x00 threshold, 0x04 wide
//   run minimum, 0x08 cross clear count, 0x0C edge clear count, 0x10 timeout.
//   Write them only while no request is in flight.
// Timing:
//   A request lands in the input register at its accepting edge; the episode
//   update between it and the result register loads the result once the
//   result slot is free or draining, which raises m_valid. One request per
//   cycle is sustained while m_ready stays high, as the episode update
//   commits each request as it leaves the input register.
// Reset (aresetn low, synchronous): configuration registers return to their
//   defaults, the episode closes and both channels empty.
// Backpressure: while m_ready is low the result holds and one more request is
//   taken into the input register; s_ready then drops until m_ready returns.
`default_nettype none

module sensor_marker_event_classifier (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_command,
    input  wire logic [7:0]                  s_sensor_bits,
    input  wire logic [31:0]                 s_frame_index,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_event_done,
    output logic [2:0]                       m_event_kind,
    output logic [7:0]                       m_edge_seen,
    output logic [7:0]                       m_all_seen,
    output logic [2:0]                       m_peak_center,
    output logic [15:0]                      m_longest_wide_run,
    output logic [31:0]                      m_first_frame,
    output logic [31:0]                      m_last_frame,
    output logic [31:0]                      m_span_frames,
    output logic [31:0]                      m_episodes_total,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [smec_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smec_pkg::DATA_W-1:0] pwdata,
    output logic [smec_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    smec_pkg::cfg_t    cfg;
    smec_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    smec_pkg::result_t out_res_reg;
    smec_pkg::result_t step_res;
    logic              out_valid_reg;
    logic              advance;
    logic              s_take;

    // Move the held request forward whenever the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    smec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smec_episode u_episode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .commit  (advance),
        .result  (step_res)
    );

    // Input register: capture a request, hold it until the update commits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.command     <= s_command;
            in_item_reg.sensor_bits <= s_sensor_bits;
            in_item_reg.frame_index <= s_frame_index;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_event_done       = out_res_reg.event_done;
    assign m_event_kind       = out_res_reg.event_kind;
    assign m_edge_seen        = out_res_reg.edge_seen;
    assign m_all_seen         = out_res_reg.all_seen;
    assign m_peak_center      = out_res_reg.peak_center;
    assign m_longest_wide_run = out_res_reg.longest_wide_run;
    assign m_first_frame      = out_res_reg.first_frame;
    assign m_last_frame       = out_res_reg.last_frame;
    assign m_span_frames      = out_res_reg.span_frames;
    assign m_episodes_total   = out_res_reg.episodes_total;

    // An empty input register always takes a request
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // A held request reaches the result register when the slot is empty
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held request did not advance");

    // A result without a closed episode carries all-zero fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_done |-> m_first_frame == 32'd0 && m_episodes_total == 32'd0
            && m_all_seen == 8'd0 && m_longest_wide_run == 16'd0)
        else $error("idle result carries nonzero fields");

    // A cross result always meets the configured wide run minimum
    a_cross_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_done && m_event_kind == smec_pkg::KIND_CROSS
            |-> m_longest_wide_run >= cfg.wide_min_frames)
        else $error("cross reported below wide run minimum");

endmodule

`default_nettype wire
